// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

// File: src/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helpers shared by the format engine modules.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int CountBits   = 16;
  localparam int DigitBuffer = 11;
  localparam int DigIdxW     = $clog2(DigitBuffer);
  localparam int DigCntW     = $clog2(DigitBuffer + 1);
  localparam int QueueDepth  = 2;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic [15:0] CapacityReset = 16'd256;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharMinus   = 8'h2d;
  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharD       = 8'h64;
  localparam logic [7:0] CharI       = 8'h69;
  localparam logic [7:0] CharX       = 8'h78;
  localparam logic [7:0] CharO       = 8'h6f;
  localparam logic [7:0] CharC       = 8'h63;

  // n / 10 == (n * DecRecip) >> DecShift for every 32-bit n.
  localparam logic [63:0] DecRecip = 64'h0000_0000_CCCC_CCCD;
  localparam int          DecShift = 35;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  format_byte;
    logic [31:0] arg_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        stored;
    logic [15:0] position;
    logic        is_terminator;
    logic        last_of_run;
    logic [15:0] total_count;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_NUM,
    KIND_END
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_OCT
  } num_base_t;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t   kind;
    num_base_t   base;
    logic [7:0]  ch;
    logic        neg;
    logic        pct;
    logic [31:0] mag;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } back_state_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'h0, v};
    end else begin
      c = 8'h57 + {4'h0, v};
    end
    return c;
  endfunction

endpackage

// File: src/printf_format_engine.sv
// ----------------------------------------------------------------------------
// printf_format_engine
// Streaming formatter for %d, %i, %x, %o and %c with bounded buffer marking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one format byte with
//   its argument word, or an end command. Output channel (out_valid /
//   out_stall / out_data) carries one generated character per transaction,
//   with its buffer position, stored flag and running count; the last one of
//   each input item has last_of_run set.
//   The front end classifies items into a two-entry command queue, so it keeps
//   accepting while the back end is busy. The back end takes a command,
//   converts a number one digit at a time (up to 10 decimal, 8 hex or 11
//   octal digits), then emits one output character at a time.
//   A lone '%' causes no output transaction.
//   The output register holds its transaction while out_stall is high; the
//   back end waits, and the front end stalls once the queue is full.
//   Synchronous reset clears the counts, the pending percent and the queue,
//   and sets capacity to 256. Write capacity through cfg_we / cfg_wdata only
//   while the block is idle.
// ----------------------------------------------------------------------------
module printf_format_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::out_item_t out_data
);

  logic               push;
  pfe_pkg::cmd_t      push_data;
  logic               pop;
  pfe_pkg::cmd_t      pop_data;
  pfe_pkg::q_status_t q_status;

  pfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  pfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: src/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Accepts format transactions, tracks a pending percent and classifies each
// byte into a command for the back end.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  input  pfe_pkg::q_status_t q_status,
  output logic               push,
  output pfe_pkg::cmd_t      push_data
);

  logic percent_pending;
  logic percent_pending_next;
  logic accept;
  logic want_push;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && want_push;

  always_comb begin
    percent_pending_next = percent_pending;
    want_push            = 1'b1;
    push_data.kind       = pfe_pkg::KIND_CHAR;
    push_data.base       = pfe_pkg::BASE_DEC;
    push_data.ch         = in_data.format_byte;
    push_data.neg        = 1'b0;
    push_data.pct        = 1'b0;
    push_data.mag        = in_data.arg_word;
    if (in_data.cmd) begin
      push_data.kind       = pfe_pkg::KIND_END;
      push_data.pct        = percent_pending;
      percent_pending_next = 1'b0;
    end else if (percent_pending) begin
      percent_pending_next = 1'b0;
      priority if (in_data.format_byte == pfe_pkg::CharD ||
                   in_data.format_byte == pfe_pkg::CharI) begin
        push_data.kind = pfe_pkg::KIND_NUM;
        push_data.neg  = in_data.arg_word[31];
        if (in_data.arg_word[31]) begin
          push_data.mag = ~in_data.arg_word + 32'd1;
        end
      end else if (in_data.format_byte == pfe_pkg::CharX) begin
        push_data.kind = pfe_pkg::KIND_NUM;
        push_data.base = pfe_pkg::BASE_HEX;
      end else if (in_data.format_byte == pfe_pkg::CharO) begin
        push_data.kind = pfe_pkg::KIND_NUM;
        push_data.base = pfe_pkg::BASE_OCT;
      end else if (in_data.format_byte == pfe_pkg::CharC) begin
        push_data.ch = in_data.arg_word[7:0];
      end else begin
        // Unknown conversion: print the percent and drop the byte.
        push_data.ch = pfe_pkg::CharPercent;
      end
    end else if (in_data.format_byte == pfe_pkg::CharPercent) begin
      percent_pending_next = 1'b1;
      want_push            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
    end else if (accept) begin
      percent_pending <= percent_pending_next;
    end
  end

endmodule

// File: src/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pfe_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pfe_pkg::cmd_t      push_data,
  input  logic               pop,
  output pfe_pkg::cmd_t      pop_data,
  output pfe_pkg::q_status_t status
);

  pfe_pkg::cmd_t                 entries [pfe_pkg::QueueDepth];
  logic [pfe_pkg::QueuePtrW-1:0] wr_ptr;
  logic [pfe_pkg::QueuePtrW-1:0] rd_ptr;
  logic [pfe_pkg::QueueCntW-1:0] count;
  logic                          do_push;
  logic                          do_pop;

  assign status.full  = (count == pfe_pkg::QueueCntW'(pfe_pkg::QueueDepth));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == pfe_pkg::QueuePtrW'(pfe_pkg::QueueDepth - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == pfe_pkg::QueuePtrW'(pfe_pkg::QueueDepth - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Executes queued commands: converts numbers one digit per cycle, then
// emits characters through an output register while keeping the counts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfe_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  pfe_pkg::q_status_t q_status,
  output logic               pop,
  input  pfe_pkg::cmd_t      pop_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::out_item_t out_data
);

  localparam logic [pfe_pkg::CountBits-1:0] CountMax = '1;

  pfe_pkg::back_state_t state;
  pfe_pkg::back_state_t state_next;

  logic [15:0]                   capacity;
  logic [pfe_pkg::CountBits-1:0] generated_count;
  logic [15:0]                   stored_length;
  logic [pfe_pkg::DigCntW-1:0]   ndig;
  logic                          pre_valid;
  logic                          term;

  logic [7:0]          pre_char;
  logic [31:0]         mag;
  pfe_pkg::num_base_t  base;
  logic [3:0]          digits [pfe_pkg::DigitBuffer];

  logic [63:0] dec_prod;
  logic [31:0] dec_q;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic        conv_done;

  logic [pfe_pkg::DigCntW-1:0]   ndig_m1;
  logic [7:0]                    cur_char;
  logic                          cur_term;
  logic                          cur_last;
  logic                          keep_char;
  logic [pfe_pkg::CountBits-1:0] gen_inc;
  logic                          out_free;
  logic                          fire;
  pfe_pkg::out_item_t            result;

  // One conversion step: quotient and remainder by the current base.
  always_comb begin
    dec_prod = {32'h0, mag} * pfe_pkg::DecRecip;
    dec_q    = 32'(dec_prod >> pfe_pkg::DecShift);
    unique case (base)
      pfe_pkg::BASE_HEX: begin
        quot = mag >> 4;
        rem  = mag[3:0];
      end
      pfe_pkg::BASE_OCT: begin
        quot = mag >> 3;
        rem  = {1'b0, mag[2:0]};
      end
      default: begin
        quot = dec_q;
        rem  = 4'(mag - ((dec_q << 3) + (dec_q << 1)));
      end
    endcase
  end

  assign conv_done = (quot == 32'h0) ||
                     (ndig == pfe_pkg::DigCntW'(pfe_pkg::DigitBuffer - 1));

  // Emission order: prefix character, digits most significant first, then,
  // for an end command, the terminator.
  assign ndig_m1 = ndig - 1'b1;

  always_comb begin
    cur_char = pfe_pkg::CharNul;
    cur_term = 1'b0;
    cur_last = 1'b1;
    if (pre_valid) begin
      cur_char = pre_char;
      cur_last = (ndig == '0) && !term;
    end else if (ndig != '0) begin
      cur_char = pfe_pkg::hex_digit(digits[ndig_m1[pfe_pkg::DigIdxW-1:0]]);
      cur_last = (ndig == pfe_pkg::DigCntW'(1)) && !term;
    end else begin
      cur_term = 1'b1;
    end
  end

  assign keep_char = ({1'b0, stored_length} + 17'd1) < {1'b0, capacity};
  assign gen_inc   = (generated_count == CountMax) ? generated_count :
                     generated_count + 1'b1;

  always_comb begin
    result.out_char      = cur_char;
    result.stored        = cur_term ? (capacity != 16'h0) : keep_char;
    result.position      = stored_length;
    result.is_terminator = cur_term;
    result.last_of_run   = cur_last;
    result.total_count   = cur_term ? 16'(generated_count) : 16'(gen_inc);
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    fire       = 1'b0;
    unique case (state)
      pfe_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = (pop_data.kind == pfe_pkg::KIND_NUM) ?
                       pfe_pkg::ST_CONV : pfe_pkg::ST_EMIT;
        end
      end
      pfe_pkg::ST_CONV: begin
        if (conv_done) begin
          state_next = pfe_pkg::ST_EMIT;
        end
      end
      pfe_pkg::ST_EMIT: begin
        if (out_free) begin
          fire = 1'b1;
          if (cur_last) begin
            state_next = pfe_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = pfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= pfe_pkg::CapacityReset;
      generated_count <= '0;
      stored_length   <= '0;
      ndig            <= '0;
      pre_valid       <= 1'b0;
      term            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        ndig      <= '0;
        term      <= (pop_data.kind == pfe_pkg::KIND_END);
        pre_valid <= (pop_data.kind == pfe_pkg::KIND_CHAR) ||
                     ((pop_data.kind == pfe_pkg::KIND_END) && pop_data.pct) ||
                     ((pop_data.kind == pfe_pkg::KIND_NUM) && pop_data.neg);
      end else if (state == pfe_pkg::ST_CONV) begin
        ndig <= ndig + 1'b1;
      end else if (fire) begin
        if (pre_valid) begin
          pre_valid <= 1'b0;
        end else if (ndig != '0) begin
          ndig <= ndig_m1;
        end
        if (cur_term) begin
          generated_count <= '0;
          stored_length   <= '0;
        end else begin
          generated_count <= gen_inc;
          if (keep_char) begin
            stored_length <= stored_length + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mag  <= pop_data.mag;
      base <= pop_data.base;
      unique case (pop_data.kind)
        pfe_pkg::KIND_CHAR: pre_char <= pop_data.ch;
        pfe_pkg::KIND_END:  pre_char <= pfe_pkg::CharPercent;
        default:            pre_char <= pfe_pkg::CharMinus;
      endcase
    end else if (state == pfe_pkg::ST_CONV) begin
      mag <= quot;
      digits[ndig[pfe_pkg::DigIdxW-1:0]] <= rem;
    end
    if (fire) begin
      out_data <= result;
    end
  end

  `ASSERT_IMPLIES(a_pop_only_idle, clk, rst, pop, state == pfe_pkg::ST_IDLE)
  `ASSERT_ALWAYS(a_ndig_bound, clk, rst,
                 ndig <= pfe_pkg::DigCntW'(pfe_pkg::DigitBuffer))
  `ASSERT_NEXT(a_term_clears, clk, rst, fire && cur_term,
               generated_count == '0 && stored_length == 16'h0)
  `ASSERT_IMPLIES(a_fire_only_emit, clk, rst, fire, state == pfe_pkg::ST_EMIT)

endmodule
